// File: rtl/dmlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmlr_pkg
// Shared types, constants and sample decode for the downmixing resampler.
// ----------------------------------------------------------------------------
package dmlr_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 20;
    localparam int STEP_W           = 20;
    localparam int SAMP_W           = 32;
    localparam int SUM_W            = 36;
    localparam int OUT_W            = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd2;

    // actions
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_SILENT = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // sample formats
    localparam logic [2:0] FMT_F32   = 3'd0;
    localparam logic [2:0] FMT_PCM8  = 3'd1;
    localparam logic [2:0] FMT_PCM16 = 3'd2;
    localparam logic [2:0] FMT_PCM24 = 3'd3;
    localparam logic [2:0] FMT_PCM32 = 3'd4;

    // queue entry from front to back: one mono sample or a clear
    typedef struct packed {
        logic                     clear;
        logic signed [SAMP_W-1:0] mono;
    } t_mono_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_EMIT
    } t_back_state;

    // float32 to Q4.28, truncated toward zero and saturated
    function automatic logic signed [SAMP_W-1:0] decode_float(input logic [31:0] w);
        logic [7:0]  e;
        logic [23:0] mant;
        logic [31:0] mag;
        logic [7:0]  sh;
        logic        neg;
        neg  = w[31];
        e    = w[30:23];
        mant = {1'b1, w[22:0]};
        mag  = '0;
        sh   = '0;
        if (e == 8'd0 || (e == 8'hFF && w[22:0] != '0)) begin
            decode_float = '0;
        end else if (e >= 8'd130) begin
            decode_float = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            if (e >= 8'd122) begin
                sh  = e - 8'd122;
                mag = {8'd0, mant} << sh[2:0];
            end else begin
                sh  = 8'd122 - e;
                mag = (sh >= 8'd32) ? 32'd0 : ({8'd0, mant} >> sh[4:0]);
            end
            decode_float = neg ? -$signed(mag) : $signed(mag);
        end
    endfunction

    function automatic logic signed [SAMP_W-1:0] decode_word(
        input logic [2:0] fmt, input logic [31:0] w);
        case (fmt)
            FMT_F32:   decode_word = decode_float(w);
            FMT_PCM8:  decode_word = $signed({~w[7], w[6:0], 24'd0}) >>> 3;
            FMT_PCM16: decode_word = $signed({w[15:0], 16'd0}) >>> 3;
            FMT_PCM24: decode_word = $signed({w[23:0], 8'd0}) >>> 3;
            FMT_PCM32: decode_word = $signed(w) >>> 3;
            default:   decode_word = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: rtl/dmlr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmlr_front
// Decodes channel words, accumulates a frame and divides it into a mono
// sample with a bit-serial restoring divider; pushes commands to the queue.
// ----------------------------------------------------------------------------
module dmlr_front #(
    parameter int MAX_CHANNELS = dmlr_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_action,
    input  wire logic [31:0]            i_sample_word,
    input  wire logic [3:0]             i_channel_count,
    input  wire logic [2:0]             i_sample_format,
    output logic                        o_push,
    output dmlr_pkg::t_mono_cmd         o_cmd,
    input  wire logic                   i_full
);
    import dmlr_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                    r_busy, n_busy;
    logic [CNT_W-1:0]        r_cnt,  n_cnt;
    logic [SUM_W-1:0]        r_quo,  n_quo;
    logic [4:0]              r_rem,  n_rem;
    logic                    r_neg,  n_neg;
    logic [4:0]              r_div,  n_div;
    logic signed [SUM_W-1:0] r_sum,  n_sum;
    logic [CH_W-1:0]         r_idx,  n_idx;
    logic                    r_pend, n_pend;
    t_mono_cmd               r_cmd,  n_cmd;

    logic [4:0]              cc;
    logic signed [SUM_W-1:0] dec_ext, acc;
    logic [SUM_W-1:0]        mag;
    logic [5:0]              trial;
    logic                    accept;

    // clamp channel count into 1..MAX_CHANNELS
    always_comb begin
        cc = {1'b0, i_channel_count};
        if (cc == 5'd0) cc = 5'd1;
        if (cc > 5'(MAX_CHANNELS)) cc = 5'(MAX_CHANNELS);
    end

    assign o_stall = r_busy || r_pend;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_pend && !i_full;
    assign o_cmd   = r_cmd;

    assign dec_ext = SUM_W'(decode_word(i_sample_format, i_sample_word));
    assign acc     = r_sum + dec_ext;
    assign mag     = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
    assign trial   = {r_rem, r_quo[SUM_W-1]};

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_quo = r_quo; n_rem = r_rem;
        n_neg = r_neg; n_div = r_div; n_sum = r_sum; n_idx = r_idx;
        n_pend = r_pend; n_cmd = r_cmd;
        if (o_push) n_pend = 1'b0;
        // one quotient bit per cycle
        if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = 5'(trial - {1'b0, r_div});
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[4:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_pend = 1'b1;
                n_cmd.clear = 1'b0;
                n_cmd.mono  = r_neg ? -SAMP_W'(n_quo) : SAMP_W'(n_quo);
            end
        end
        if (accept) begin
            case (i_action)
                ACT_CLEAR: begin
                    n_sum = '0; n_idx = '0;
                    n_pend = 1'b1; n_cmd.clear = 1'b1; n_cmd.mono = '0;
                end
                ACT_SILENT: begin
                    n_sum = '0; n_idx = '0;
                    n_pend = 1'b1; n_cmd.clear = 1'b0; n_cmd.mono = '0;
                end
                ACT_SAMPLE: begin
                    if ({1'b0, r_idx} + 5'd1 < cc) begin
                        n_sum = acc;
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_sum  = '0;
                        n_idx  = '0;
                        n_busy = 1'b1;
                        n_cnt  = CNT_W'(SUM_W);
                        n_quo  = mag;
                        n_rem  = '0;
                        n_neg  = acc[SUM_W-1];
                        n_div  = cc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_sum  <= '0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
            r_sum  <= n_sum;
            r_idx  <= n_idx;
        end
        r_cnt <= n_cnt; r_quo <= n_quo; r_rem <= n_rem;
        r_neg <= n_neg; r_div <= n_div; r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

// File: rtl/dmlr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmlr_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module dmlr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dmlr_pkg::t_mono_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_avail,
    output dmlr_pkg::t_mono_cmd o_cmd
);
    import dmlr_pkg::*;

    t_mono_cmd  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule
`default_nettype wire

// File: rtl/dmlr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmlr_back
// Phase accumulator, linear interpolation, clamp and scale to 16-bit output.
// ----------------------------------------------------------------------------
module dmlr_back #(
    parameter int FRAC_BITS = dmlr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_avail,
    input  wire dmlr_pkg::t_mono_cmd  i_cmd,
    output logic                      o_pop,
    input  wire logic [19:0]          i_step_ratio,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [15:0]        o_sample_out,
    output logic                      o_last_of_run
);
    import dmlr_pkg::*;

    localparam int PH_W  = FRAC_BITS + 5;
    localparam int PR_W  = SAMP_W + FRAC_BITS + 2;
    localparam int MAG_W = 28 + FRAC_BITS + 1;
    localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << FRAC_BITS;

    t_back_state r_st, n_st;
    logic signed [SAMP_W-1:0] r_prev, n_prev, r_cur, n_cur;
    logic                     r_have, n_have;
    logic [PH_W-1:0]          r_phase, n_phase;
    logic [1:0]               r_n, n_n;
    logic signed [PR_W-1:0]   r_pa, n_pa, r_pb, n_pb;
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic                     r_sneg, n_sneg;
    logic                     r_ov, n_ov;
    logic signed [OUT_W-1:0]  r_out, n_out;
    logic                     r_last, n_last;

    logic [PH_W-1:0]          step, ph_adv;
    logic [FRAC_BITS:0]       frac, wprev;
    logic signed [PR_W-1:0]   vsum;
    logic [PR_W-1:0]          vabs;
    logic [MAG_W+15-1:0]      scaled;
    logic [OUT_W-1:0]         o_mag;

    always_comb begin
        step = PH_W'(i_step_ratio);
        if (step < (PH_ONE >> 1)) step = PH_ONE >> 1;
    end

    assign frac   = {1'b0, r_phase[FRAC_BITS-1:0]};
    assign wprev  = (FRAC_BITS+1)'(PH_ONE) - frac;
    assign ph_adv = r_phase + step;
    assign vsum   = r_pa + r_pb;
    assign vabs   = vsum[PR_W-1] ? PR_W'(-vsum) : PR_W'(vsum);
    // mag*32767 >> (28+F) equals q*32767 + (r*32767 >> F) >> 28
    assign scaled = (MAG_W+15)'(r_mag) * (MAG_W+15)'(15'd32767);
    assign o_mag  = OUT_W'(scaled >> (28 + FRAC_BITS));

    // beat is offered once the scaled value sits in r_out
    assign o_valid       = (r_st == ST_EMIT) && r_ov;
    assign o_sample_out  = r_out;
    assign o_last_of_run = r_last;

    always_comb begin
        n_st = r_st; n_prev = r_prev; n_cur = r_cur; n_have = r_have;
        n_phase = r_phase; n_n = r_n; n_pa = r_pa; n_pb = r_pb;
        n_mag = r_mag; n_sneg = r_sneg; n_ov = r_ov; n_out = r_out; n_last = r_last;
        o_pop = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (i_cmd.clear) begin
                        n_prev = '0; n_have = 1'b0; n_phase = '0;
                    end else if (!r_have) begin
                        n_prev = i_cmd.mono; n_have = 1'b1;
                    end else if (r_phase >= PH_ONE) begin
                        n_phase = r_phase - PH_ONE;
                        n_prev  = i_cmd.mono;
                    end else begin
                        n_cur = i_cmd.mono;
                        n_n   = 2'd0;
                        n_st  = ST_MUL;
                    end
                end
            end
            // two products, registered
            ST_MUL: begin
                n_pa = PR_W'(r_prev) * $signed({1'b0, wprev});
                n_pb = PR_W'(r_cur) * $signed({1'b0, frac});
                n_n  = r_n + 2'd1;
                n_phase = ph_adv;
                n_st = ST_SCALE;
            end
            ST_SCALE: begin
                n_sneg = vsum[PR_W-1];
                n_mag  = (vabs > PR_W'(MAG_W'(1) << (28 + FRAC_BITS)))
                         ? (MAG_W'(1) << (28 + FRAC_BITS)) : MAG_W'(vabs);
                n_ov   = 1'b0;
                n_st   = ST_EMIT;
            end
            ST_EMIT: begin
                n_out  = r_sneg ? -$signed(o_mag) : $signed(o_mag);
                n_last = !(r_phase < PH_ONE && r_n < 2'd2);
                if (r_ov) begin
                    if (!i_stall) begin
                        n_ov = 1'b0;
                        if (r_last) begin
                            if (r_phase >= PH_ONE) n_phase = r_phase - PH_ONE;
                            n_prev = r_cur;
                            n_st   = ST_IDLE;
                        end else begin
                            n_st = ST_MUL;
                        end
                    end
                end else begin
                    n_ov = 1'b1;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_have <= 1'b0; r_phase <= '0; r_prev <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_have <= n_have; r_phase <= n_phase; r_prev <= n_prev;
            r_ov <= n_ov;
        end
        r_cur <= n_cur; r_n <= n_n; r_pa <= n_pa; r_pb <= n_pb;
        r_mag <= n_mag; r_sneg <= n_sneg; r_out <= n_out; r_last <= n_last;
    end

endmodule
`default_nettype wire

// File: rtl/downmix_linear_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// Downmixes interleaved capture words to mono and resamples them.
// ----------------------------------------------------------------------------
// A channel word that does not close a frame is decoded and accumulated. A word
// that closes a frame runs a bit-serial divider in the front part that stalls
// new words until the quotient is pushed, and the back part then takes each
// result through multiply, clamp, scale and present. A two-entry queue lets the
// front decode the next frame while the back part is still producing results.
module downmix_linear_resampler #(
    parameter int MAX_CHANNELS = dmlr_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = dmlr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dmlr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dmlr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic [31:0]                   i_sample_word,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [15:0]                 o_sample_out,
    output logic                               o_last_of_run
);
    import dmlr_pkg::*;

    logic [19:0] r_step;
    logic [3:0]  r_chan;
    logic [2:0]  r_fmt;
    logic        push, full, pop, avail;
    t_mono_cmd   f_cmd, q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 20'd65536;
            r_chan <= 4'd1;
            r_fmt  <= FMT_PCM16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP:   r_step <= i_cfg_data[19:0];
                REG_CHAN:   r_chan <= i_cfg_data[3:0];
                REG_FORMAT: r_fmt  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    dmlr_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action, .i_sample_word,
        .i_channel_count(r_chan), .i_sample_format(r_fmt),
        .o_push(push), .o_cmd(f_cmd), .i_full(full)
    );

    dmlr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(f_cmd), .o_full(full),
        .i_pop(pop), .o_avail(avail), .o_cmd(q_cmd)
    );

    dmlr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_cmd(q_cmd), .o_pop(pop),
        .i_step_ratio(r_step), .o_valid, .i_stall, .o_sample_out, .o_last_of_run
    );

endmodule
`default_nettype wire
